// ===== src/sfpb_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the sliding FFT peak tracker.
// Depends on nothing; the butterfly, top and testbench files refer to it by scoped names.
package sfpb_pkg;

    // Window and number formats
    localparam int POINTS      = 256;
    localparam int LOG2_POINTS = $clog2(POINTS);
    localparam int HALF        = POINTS / 2;
    localparam int HOP         = POINTS / 4;
    localparam int HOP_W       = $clog2(HOP);
    localparam int SAMPLE_BITS = 10;
    localparam int TW_BITS     = 16;
    localparam int WORK_BITS   = 24;
    localparam int BIN_W       = LOG2_POINTS - 1;
    localparam int STAGE_W     = $clog2(LOG2_POINTS);
    localparam int ROM_IDX_W   = $clog2(HOP + 1);
    localparam int SQ_W        = 2 * WORK_BITS - 1;
    localparam int MAG_W       = SQ_W + 1;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((BIN_W + 7) / 8) * 8;

    // Complex work value as stored in the work memory
    typedef struct packed {
        logic signed [WORK_BITS-1:0] im;
        logic signed [WORK_BITS-1:0] re;
    } cplx_t;

    localparam int CPLX_W = $bits(cplx_t);

    // Butterfly unit strobes
    typedef struct packed {
        logic mul1;   // latch B operand, first product pair
        logic mul2;   // second product pair, round real part
    } bf_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BF_RDA,
        ST_BF_RDB,
        ST_BF_MUL1,
        ST_BF_MUL2,
        ST_BF_WRA,
        ST_BF_WRB,
        ST_PEAK,
        ST_OUT
    } state_t;

    typedef logic signed [TW_BITS-1:0] sine_rom_t [HOP+1];

    // Q30 Taylor series sine, evaluated at elaboration only
    function automatic logic signed [63:0] sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 10; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        return sum;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic signed [63:0] s;
        logic signed [63:0] v;
        logic signed [63:0] full;
        full = (64'sd1 <<< (TW_BITS - 1)) - 64'sd1;
        for (int i = 0; i <= HOP; i++) begin
            x = (64'd3373259426 * 64'(i)) / 64'(HALF);
            s = sin_q30(x);
            v = (s * (64'sd1 <<< (TW_BITS - 1)) + (64'sd1 <<< 29)) >>> 30;
            if (v > full) begin
                v = full;
            end
            rom[i] = TW_BITS'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ===== src/sfpb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sfpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sfpb_bfly.sv =====
// Radix-2 butterfly datapath: complex twiddle multiply under the mul1 and mul2 strobes, rounding, saturation.
// Depends on sfpb_pkg.
module sfpb_bfly (
    input  logic                                 aclk,
    input  sfpb_pkg::bf_ctl_t                    ctl,
    input  sfpb_pkg::cplx_t                      x,
    input  sfpb_pkg::cplx_t                      b_in,
    input  logic signed [sfpb_pkg::TW_BITS-1:0]  wr,
    input  logic signed [sfpb_pkg::TW_BITS-1:0]  wi,
    output sfpb_pkg::cplx_t                      sum_o,
    output sfpb_pkg::cplx_t                      dif_o
);

    localparam int PROD_W = sfpb_pkg::WORK_BITS + sfpb_pkg::TW_BITS;
    localparam int SHIFT  = sfpb_pkg::TW_BITS - 1;
    localparam int RND_W  = PROD_W + 2 - SHIFT;
    localparam int WB     = sfpb_pkg::WORK_BITS;

    sfpb_pkg::cplx_t          b_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [RND_W-1:0]  tr_reg;
    logic signed [RND_W-1:0]  ti;

    // add half an LSB, then floor shift
    function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W:0] v);
        logic signed [PROD_W+1:0] w;
        w = (PROD_W+2)'(v) + (PROD_W+2)'(1 <<< (SHIFT - 1));
        w = w >>> SHIFT;
        return RND_W'(w);
    endfunction

    function automatic logic signed [WB-1:0] sat(input logic signed [RND_W:0] v);
        logic [RND_W-WB+1:0] top;
        top = v[RND_W:WB-1];
        if (top == '0 || top == '1) begin
            return v[WB-1:0];
        end else if (v[RND_W]) begin
            return {1'b1, {(WB-1){1'b0}}};
        end else begin
            return {1'b0, {(WB-1){1'b1}}};
        end
    endfunction

    // product stages
    always_ff @(posedge aclk) begin
        if (ctl.mul1) begin
            b_reg  <= b_in;
            p1_reg <= PROD_W'(b_in.re) * PROD_W'(wr);
            p2_reg <= PROD_W'(b_in.im) * PROD_W'(wi);
        end
        if (ctl.mul2) begin
            p3_reg <= PROD_W'(b_reg.re) * PROD_W'(wi);
            p4_reg <= PROD_W'(b_reg.im) * PROD_W'(wr);
            tr_reg <= rnd((PROD_W+1)'(p1_reg) - (PROD_W+1)'(p2_reg));
        end
    end

    // sum and difference with saturation
    always_comb begin
        ti       = rnd((PROD_W+1)'(p3_reg) + (PROD_W+1)'(p4_reg));
        sum_o.re = sat((RND_W+1)'(x.re) + (RND_W+1)'(tr_reg));
        sum_o.im = sat((RND_W+1)'(x.im) + (RND_W+1)'(ti));
        dif_o.re = sat((RND_W+1)'(x.re) - (RND_W+1)'(tr_reg));
        dif_o.im = sat((RND_W+1)'(x.im) - (RND_W+1)'(ti));
    end

endmodule

// ===== src/sliding_fft_peak_bin_top.sv =====
// Frame: the 64th sample of a hop is followed by a load pass, the butterfly passes (1024 butterflies,
// one work-memory write port), a scan of the bins and an output state that raises m_tvalid.
// Other samples are accepted only while idle; s_tready is low while a frame is processed.
// Reset (aresetn low, synchronous) clears control only; unwritten window entries read as zero
// through a fill count, so there is no clearing pass.
// Depends on sfpb_pkg, sfpb_ram and sfpb_bfly.
module sliding_fft_peak_bin_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sfpb_pkg::S_TDATA_W-1:0]   s_tdata,   // [9:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sfpb_pkg::M_TDATA_W-1:0]   m_tdata    // [6:0] peak_bin
);

    localparam int AW = sfpb_pkg::LOG2_POINTS;

    sfpb_pkg::state_t  state_reg, state_next;
    sfpb_pkg::bf_ctl_t bf_ctl;

    logic [sfpb_pkg::HOP_W-1:0] hop_reg;
    logic [AW-1:0]              wp_reg;
    logic [AW:0]                fill_reg;
    logic [AW:0]                ld_cnt_reg;
    logic                       ld_wr_reg, ld_ok_reg;
    logic [AW-1:0]              ld_idx_reg;
    logic [sfpb_pkg::STAGE_W-1:0] stage_reg;
    logic [AW-2:0]              jj_reg;
    logic [AW-1:0]              kk_reg;
    sfpb_pkg::cplx_t            x_reg, dif_reg;
    logic signed [sfpb_pkg::TW_BITS-1:0] tw_wr_reg, tw_wi_reg;
    logic [AW-1:0]              pk_cnt_reg;
    logic                       pk_v1_reg, pk_v2_reg;
    logic [sfpb_pkg::BIN_W-1:0] pk_i1_reg, pk_i2_reg, best_reg, out_bin_reg;
    logic [sfpb_pkg::SQ_W-1:0]  rr_reg, mm_reg;
    logic [sfpb_pkg::MAG_W-1:0] best_mag_reg, mag;
    logic                       out_valid_reg;

    logic                       s_accept;
    logic [AW-1:0]              win_raddr;
    logic [sfpb_pkg::SAMPLE_BITS-1:0] win_rdata;
    logic                       work_we;
    logic [AW-1:0]              work_waddr, work_raddr;
    sfpb_pkg::cplx_t            work_wdata, work_rdata, ld_val, bf_sum, bf_dif;
    logic [AW-1:0]              span, kb;
    logic [AW:0]                kk_step;
    logic [AW-1:0]              jj_inc;
    logic                       last_group, last_stage, kk_wrap;
    logic [AW-1:0]              kk_nxt;
    logic [sfpb_pkg::BIN_W-1:0] tw_idx;
    logic [AW-1:0]              tw_half_m;
    logic signed [sfpb_pkg::TW_BITS-1:0] sin_v, cos_v;
    logic signed [2*sfpb_pkg::WORK_BITS-1:0] sq_re, sq_im;
    logic                       out_load;

    function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int i = 0; i < AW; i++) begin
            r[i] = v[AW-1-i];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == sfpb_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sfpb_pkg::M_TDATA_W'(out_bin_reg);

    // Memories
    sfpb_ram #(.WIDTH(sfpb_pkg::SAMPLE_BITS), .DEPTH(sfpb_pkg::POINTS)) u_win_ram (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wp_reg),
        .wdata (s_tdata[sfpb_pkg::SAMPLE_BITS-1:0]),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    sfpb_ram #(.WIDTH(sfpb_pkg::CPLX_W), .DEPTH(sfpb_pkg::POINTS)) u_work_ram (
        .aclk  (aclk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    sfpb_bfly u_bfly (
        .aclk  (aclk),
        .ctl   (bf_ctl),
        .x     (x_reg),
        .b_in  (work_rdata),
        .wr    (tw_wr_reg),
        .wi    (tw_wi_reg),
        .sum_o (bf_sum),
        .dif_o (bf_dif)
    );

    // Butterfly index stepping: kk inner, jj middle, stage outer
    always_comb begin
        span       = AW'(1) << stage_reg;
        kb         = kk_reg + span;
        kk_step    = {1'b0, kk_reg} + {span, 1'b0};
        jj_inc     = {1'b0, jj_reg} + AW'(1);
        last_group = (jj_inc == span);
        last_stage = (stage_reg == sfpb_pkg::STAGE_W'(AW - 1));
        kk_wrap    = kk_step[AW];
        if (!kk_wrap) begin
            kk_nxt = kk_step[AW-1:0];
        end else if (!last_group) begin
            kk_nxt = jj_inc;
        end else begin
            kk_nxt = '0;
        end
    end

    // Twiddle from the quarter-wave table
    always_comb begin
        tw_idx    = sfpb_pkg::BIN_W'({jj_reg} << (sfpb_pkg::STAGE_W'(AW - 1) - stage_reg));
        tw_half_m = AW'(sfpb_pkg::HALF) - AW'(tw_idx);
        if (tw_idx <= sfpb_pkg::BIN_W'(sfpb_pkg::HOP)) begin
            sin_v = sfpb_pkg::SINE_ROM[sfpb_pkg::ROM_IDX_W'(tw_idx)];
        end else begin
            sin_v = sfpb_pkg::SINE_ROM[sfpb_pkg::ROM_IDX_W'(tw_half_m)];
        end
        if (tw_idx < sfpb_pkg::BIN_W'(sfpb_pkg::HOP)) begin
            cos_v = sfpb_pkg::SINE_ROM[sfpb_pkg::ROM_IDX_W'(sfpb_pkg::BIN_W'(sfpb_pkg::HOP)
                                                          - tw_idx)];
        end else begin
            cos_v = -sfpb_pkg::SINE_ROM[sfpb_pkg::ROM_IDX_W'(tw_idx
                                                           - sfpb_pkg::BIN_W'(sfpb_pkg::HOP))];
        end
    end

    // Memory address and data selection
    always_comb begin
        win_raddr   = wp_reg + ld_cnt_reg[AW-1:0];
        ld_val.re   = ld_ok_reg ? sfpb_pkg::WORK_BITS'(win_rdata) : '0;
        ld_val.im   = '0;
        work_we     = 1'b0;
        work_waddr  = kk_reg;
        work_wdata  = bf_sum;
        work_raddr  = kk_reg;
        case (state_reg)
            sfpb_pkg::ST_LOAD: begin
                work_we    = ld_wr_reg;
                work_waddr = bitrev(ld_idx_reg);
                work_wdata = ld_val;
            end
            sfpb_pkg::ST_BF_RDB: begin
                work_raddr = kb;
            end
            sfpb_pkg::ST_BF_WRA: begin
                work_we = 1'b1;
            end
            sfpb_pkg::ST_BF_WRB: begin
                work_we    = 1'b1;
                work_waddr = kb;
                work_wdata = dif_reg;
                work_raddr = kk_nxt;
            end
            sfpb_pkg::ST_PEAK: begin
                work_raddr = pk_cnt_reg;
            end
            default: begin
            end
        endcase
    end

    // Next state and strobes
    always_comb begin
        state_next  = state_reg;
        bf_ctl.mul1 = 1'b0;
        bf_ctl.mul2 = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            sfpb_pkg::ST_IDLE: begin
                if (s_accept && hop_reg == sfpb_pkg::HOP_W'(sfpb_pkg::HOP - 1)) begin
                    state_next = sfpb_pkg::ST_LOAD;
                end
            end
            sfpb_pkg::ST_LOAD: begin
                if (ld_cnt_reg[AW]) begin
                    state_next = sfpb_pkg::ST_BF_RDA;
                end
            end
            sfpb_pkg::ST_BF_RDA: state_next = sfpb_pkg::ST_BF_RDB;
            sfpb_pkg::ST_BF_RDB: state_next = sfpb_pkg::ST_BF_MUL1;
            sfpb_pkg::ST_BF_MUL1: begin
                bf_ctl.mul1 = 1'b1;
                state_next  = sfpb_pkg::ST_BF_MUL2;
            end
            sfpb_pkg::ST_BF_MUL2: begin
                bf_ctl.mul2 = 1'b1;
                state_next  = sfpb_pkg::ST_BF_WRA;
            end
            sfpb_pkg::ST_BF_WRA: state_next = sfpb_pkg::ST_BF_WRB;
            sfpb_pkg::ST_BF_WRB: begin
                if (kk_wrap && last_group && last_stage) begin
                    state_next = sfpb_pkg::ST_PEAK;
                end else begin
                    state_next = sfpb_pkg::ST_BF_RDB;
                end
            end
            sfpb_pkg::ST_PEAK: begin
                if (pk_v2_reg && pk_i2_reg == sfpb_pkg::BIN_W'(sfpb_pkg::HALF - 1)) begin
                    state_next = sfpb_pkg::ST_OUT;
                end
            end
            sfpb_pkg::ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = sfpb_pkg::ST_IDLE;
                end
            end
            default: state_next = sfpb_pkg::ST_IDLE;
        endcase
    end

    // Magnitude of the bin arriving from memory
    always_comb begin
        sq_re = work_rdata.re * work_rdata.re;
        sq_im = work_rdata.im * work_rdata.im;
        mag   = sfpb_pkg::MAG_W'(rr_reg) + sfpb_pkg::MAG_W'(mm_reg);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sfpb_pkg::ST_IDLE;
            hop_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            ld_wr_reg     <= 1'b0;
            pk_v1_reg     <= 1'b0;
            pk_v2_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                hop_reg <= hop_reg + sfpb_pkg::HOP_W'(1);
                wp_reg  <= wp_reg + AW'(1);
                if (!fill_reg[AW]) begin
                    fill_reg <= fill_reg + (AW+1)'(1);
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            ld_wr_reg <= (state_reg == sfpb_pkg::ST_LOAD) && !ld_cnt_reg[AW];
            pk_v1_reg <= (state_reg == sfpb_pkg::ST_PEAK)
                         && (pk_cnt_reg < AW'(sfpb_pkg::HALF));
            pk_v2_reg <= pk_v1_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        tw_wr_reg <= cos_v;
        tw_wi_reg <= -sin_v;
        ld_idx_reg <= ld_cnt_reg[AW-1:0];
        ld_ok_reg  <= fill_reg[AW] || ({1'b0, win_raddr} < fill_reg);
        if (state_reg == sfpb_pkg::ST_LOAD) begin
            ld_cnt_reg <= ld_cnt_reg + (AW+1)'(1);
        end else begin
            ld_cnt_reg <= '0;
        end
        if (state_reg == sfpb_pkg::ST_LOAD) begin
            stage_reg <= '0;
            jj_reg    <= '0;
            kk_reg    <= '0;
        end
        if (state_reg == sfpb_pkg::ST_BF_RDB) begin
            x_reg <= work_rdata;
        end
        if (state_reg == sfpb_pkg::ST_BF_WRA) begin
            dif_reg <= bf_dif;
        end
        if (state_reg == sfpb_pkg::ST_BF_WRB) begin
            kk_reg <= kk_nxt;
            if (kk_wrap) begin
                if (last_group) begin
                    stage_reg <= stage_reg + sfpb_pkg::STAGE_W'(1);
                    jj_reg    <= '0;
                end else begin
                    jj_reg <= jj_inc[AW-2:0];
                end
            end
        end
        // peak scan: read, square, compare
        if (state_reg == sfpb_pkg::ST_PEAK) begin
            pk_cnt_reg <= pk_cnt_reg + AW'(1);
        end else begin
            pk_cnt_reg <= AW'(1);
        end
        pk_i1_reg <= pk_cnt_reg[sfpb_pkg::BIN_W-1:0];
        pk_i2_reg <= pk_i1_reg;
        rr_reg    <= sq_re[sfpb_pkg::SQ_W-1:0];
        mm_reg    <= sq_im[sfpb_pkg::SQ_W-1:0];
        if (pk_v2_reg) begin
            if (pk_i2_reg == sfpb_pkg::BIN_W'(1) || mag > best_mag_reg) begin
                best_mag_reg <= mag;
                best_reg     <= pk_i2_reg;
            end
        end
        if (out_load) begin
            out_bin_reg <= best_reg;
        end
    end

    // Checks
    a_no_work_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sfpb_pkg::ST_IDLE |-> !work_we)
        else $error("work memory written while idle");

    a_hop_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && hop_reg == sfpb_pkg::HOP_W'(sfpb_pkg::HOP - 1)
        |=> state_reg == sfpb_pkg::ST_LOAD)
        else $error("frame not started after a full hop");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == sfpb_pkg::ST_OUT))
        else $error("result raised outside output state");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (AW+1)'(sfpb_pkg::POINTS))
        else $error("fill count beyond window");

endmodule

// ===== sim/sliding_fft_peak_bin_top_tb.sv =====
// Self-checking testbench for sliding_fft_peak_bin_top: streams ADC samples, predicts the peak
// bin of each 256-point window with a local fixed-point FFT, and checks every m_tdata result.
// Depends on sfpb_pkg (formats and sine table) and the RTL of sliding_fft_peak_bin_top.
`timescale 1ns / 100ps

module sliding_fft_peak_bin_top_tb;

    localparam int STALL_LIMIT = 60000;   // idle cycles before the watchdog fires
    localparam int LONG_HOLD   = 14000;   // receiver hold-off, longer than two frames
    localparam int TW_ROUND    = sfpb_pkg::TW_BITS - 1;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [sfpb_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [sfpb_pkg::M_TDATA_W-1:0] m_tdata;

    sliding_fft_peak_bin_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: sample window and hop counter
    logic [sfpb_pkg::SAMPLE_BITS-1:0] window_q [sfpb_pkg::POINTS];
    int unsigned                      hop_cnt;
    logic [sfpb_pkg::BIN_W-1:0]       peak_bins_q [$];

    int  error_cnt = 0;
    bit  no_idle;        // forces zero gaps on both sides
    int  hold_req_cnt;   // each increment asks the receiver for one long hold-off
    int  quiet_cycles;

    // Saturate to the signed work width
    function automatic longint sat_work(input longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (sfpb_pkg::WORK_BITS - 1)) - 1;
        lo = -(longint'(1) <<< (sfpb_pkg::WORK_BITS - 1));
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Fixed-point DIT FFT of the current window and scan of bins 1..HALF-1
    function automatic logic [sfpb_pkg::BIN_W-1:0] peak_of_window();
        longint      re [sfpb_pkg::POINTS];
        longint      im [sfpb_pkg::POINTS];
        longint      s, c, ar, ai, tr, ti, xr, xi;
        longint      mag, best_mag;
        int unsigned t, kb, best;
        logic [sfpb_pkg::LOG2_POINTS-1:0] idx, rev;
        for (int i = 0; i < sfpb_pkg::POINTS; i++) begin
            idx = sfpb_pkg::LOG2_POINTS'(i);
            rev = {<<{idx}};
            re[rev] = longint'(window_q[i]);
            im[rev] = 0;
        end
        for (int b = 1; b < sfpb_pkg::POINTS; b = b * 2) begin
            for (int jj = 0; jj < b; jj++) begin
                t = (jj * sfpb_pkg::HALF) / b;
                s = (t <= sfpb_pkg::HOP) ? longint'(sfpb_pkg::SINE_ROM[t])
                                         : longint'(sfpb_pkg::SINE_ROM[sfpb_pkg::HALF - t]);
                c = (t < sfpb_pkg::HOP) ? longint'(sfpb_pkg::SINE_ROM[sfpb_pkg::HOP - t])
                                        : -longint'(sfpb_pkg::SINE_ROM[t - sfpb_pkg::HOP]);
                // W = c - j*s
                for (int kk = jj; kk + b < sfpb_pkg::POINTS; kk += 2 * b) begin
                    kb = kk + b;
                    ar = re[kb];
                    ai = im[kb];
                    tr = (ar * c + ai * s + (longint'(1) <<< (TW_ROUND - 1))) >>> TW_ROUND;
                    ti = (ai * c - ar * s + (longint'(1) <<< (TW_ROUND - 1))) >>> TW_ROUND;
                    xr = re[kk];
                    xi = im[kk];
                    re[kb] = sat_work(xr - tr);
                    im[kb] = sat_work(xi - ti);
                    re[kk] = sat_work(xr + tr);
                    im[kk] = sat_work(xi + ti);
                end
            end
        end
        best     = 1;
        best_mag = 0;
        for (int i = 1; i < sfpb_pkg::HALF; i++) begin
            mag = re[i] * re[i] + im[i] * im[i];
            if (i == 1 || mag > best_mag) begin
                best_mag = mag;
                best     = i;
            end
        end
        return sfpb_pkg::BIN_W'(best);
    endfunction

    // Shift an accepted sample into the window; queue a result at each hop boundary
    function automatic void take_sample(input logic [sfpb_pkg::SAMPLE_BITS-1:0] v);
        for (int i = 0; i < sfpb_pkg::POINTS - 1; i++) begin
            window_q[i] = window_q[i + 1];
        end
        window_q[sfpb_pkg::POINTS - 1] = v;
        hop_cnt++;
        if (hop_cnt >= sfpb_pkg::HOP) begin
            hop_cnt = 0;
            peak_bins_q.push_back(peak_of_window());
        end
    endfunction

    // Offer one sample and wait for the transaction, then an optional gap
    task automatic send_sample(input logic [sfpb_pkg::SAMPLE_BITS-1:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= sfpb_pkg::S_TDATA_W'(v);
        do begin
            @(posedge aclk);
        end while (!s_tready);
        take_sample(v);
        gap = no_idle ? 0 : $urandom_range(9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Clipped tone around mid-scale
    function automatic logic [sfpb_pkg::SAMPLE_BITS-1:0] tone_sample(input int bin,
                                                                    input int amp,
                                                                    input int n,
                                                                    input real ph);
        real v;
        v = 512.0 + amp * $sin(2.0 * 3.14159265358979 * bin * n / sfpb_pkg::POINTS + ph);
        if (v < 0.0) begin
            v = 0.0;
        end
        if (v > 1023.0) begin
            v = 1023.0;
        end
        return sfpb_pkg::SAMPLE_BITS'(int'(v));
    endfunction

    // Receiver: random stalls, optional long hold-off, field check on each transaction
    initial begin
        int wait_cycles;
        int holds_served;
        logic [sfpb_pkg::BIN_W-1:0] want;
        holds_served = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req_cnt != holds_served) begin
                holds_served = hold_req_cnt;
                wait_cycles  = LONG_HOLD;
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(9);
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!(m_tvalid && m_tready));
            if (peak_bins_q.size() == 0) begin
                $error("unexpected transaction: peak_bin actual %0d",
                       m_tdata[sfpb_pkg::BIN_W-1:0]);
                error_cnt++;
            end else begin
                want = peak_bins_q.pop_front();
                if (m_tdata[sfpb_pkg::BIN_W-1:0] !== want) begin
                    $error("peak_bin mismatch: expected %0d actual %0d", want,
                           m_tdata[sfpb_pkg::BIN_W-1:0]);
                    error_cnt++;
                end
                if (m_tdata[sfpb_pkg::M_TDATA_W-1:sfpb_pkg::BIN_W] !== '0) begin
                    $error("m_tdata pad mismatch: expected 0 actual %0h",
                           m_tdata[sfpb_pkg::M_TDATA_W-1:sfpb_pkg::BIN_W]);
                    error_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("sliding_fft_peak_bin_top_tb: errors");
                $finish;
            end
        end
    end

    // Extremes, bit patterns and a silent start: first frame is all zero except its end
    task automatic test_corners();
        send_sample('0);
        send_sample('1);
        for (int b = 0; b < sfpb_pkg::SAMPLE_BITS; b++) begin
            send_sample(sfpb_pkg::SAMPLE_BITS'(1) << b);
            send_sample(~(sfpb_pkg::SAMPLE_BITS'(1) << b));
        end
        send_sample(10'h2AA);
        send_sample(10'h155);
        // pad the first hop with zeros so the start-up frame fires
        while (hop_cnt != 0) send_sample('0);
    endtask

    // Full-scale square waves, constant levels and Nyquist toggling
    task automatic test_extreme_frames();
        for (int n = 0; n < sfpb_pkg::HOP; n++) send_sample('1);
        for (int n = 0; n < sfpb_pkg::HOP; n++) send_sample((n % 2) ? '1 : '0);
        for (int n = 0; n < sfpb_pkg::HOP; n++) send_sample((n % 16 < 8) ? '1 : '0);
        for (int n = 0; n < sfpb_pkg::POINTS; n++) send_sample(sfpb_pkg::SAMPLE_BITS'(512));
    endtask

    // Pure tones at random bins with random amplitude and phase
    task automatic test_tones(input int frames);
        int  bin, amp;
        real ph;
        for (int f = 0; f < frames; f++) begin
            bin = $urandom_range(sfpb_pkg::HALF - 1, 1);
            amp = $urandom_range(511, 1);
            ph  = $urandom_range(628) / 100.0;
            for (int n = 0; n < sfpb_pkg::HOP; n++) begin
                send_sample(tone_sample(bin, amp, n + 64 * f, ph));
            end
        end
    endtask

    // White noise frames
    task automatic test_noise(input int frames);
        for (int n = 0; n < frames * sfpb_pkg::HOP; n++) begin
            send_sample(sfpb_pkg::SAMPLE_BITS'($urandom));
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        hold_req_cnt++;
        test_tones(3);
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        no_idle      = 1'b0;
        hold_req_cnt = 0;
        hop_cnt      = 0;
        foreach (window_q[i]) window_q[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corners();
        test_extreme_frames();
        test_tones(4);
        test_backpressure();
        no_idle = 1'b1;
        test_tones(4);
        test_noise(2);
        no_idle = 1'b0;
        test_noise(2);
        test_tones(4);
        test_backpressure();

        s_tvalid <= 1'b0;
        while (peak_bins_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("sliding_fft_peak_bin_top_tb: clean");
        end else begin
            $display("sliding_fft_peak_bin_top_tb: errors");
        end
        $finish;
    end

endmodule
